// ===== src/pulse_flow_rate_meter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Pulse flow rate meter: assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PULSE_FLOW_RATE_METER_UNIT_MACROS_SVH
`define PULSE_FLOW_RATE_METER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PFRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfrm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PFRM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfrm: next-cycle check failed");

`endif

// ===== src/pfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse flow rate meter: package
// Field widths, item kind and register index codes, transaction types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfrm_pkg;

   localparam int TIME_WIDTH          = 32;
   localparam int PPL_WIDTH           = 24;
   localparam int FLOW_WIDTH          = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int FLOW_FRAC_BITS_DEF  = 8;

   // Sixty million microseconds per minute, and the bits it needs.
   localparam longint FLOW_SCALE       = 60000000;
   localparam int     FLOW_SCALE_WIDTH = 26;

   localparam logic [PPL_WIDTH-1:0]  PPL_RESET     = PPL_WIDTH'(115200);
   localparam logic [TIME_WIDTH-1:0] MIN_GAP_RESET = '0;
   localparam logic [TIME_WIDTH-1:0] TIMEOUT_RESET = TIME_WIDTH'(1500000);

   localparam logic [1:0] KIND_EDGE  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PPL     = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_GAP = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT = CSR_INDEX_WIDTH'(2);

   typedef struct packed {
      logic [1:0]            kind;
      logic [TIME_WIDTH-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic [31:0]           pulse_count;
      logic [TIME_WIDTH-1:0] pulse_interval_us;
      logic [FLOW_WIDTH-1:0] raw_flow_q8;
      logic [FLOW_WIDTH-1:0] filtered_flow_q8;
      logic                  edge_rejected;
   } rsp_type;

endpackage

// ===== src/pulse_flow_rate_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Pulse flow rate meter
// Counts debounced sensor pulses, measures the pulse period and, on update
// ticks, turns it into flow in L/min with a quarter-weight moving average.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         valid / stall      req_type (kind, now_us)
//   rsp_      out        valid / stall      rsp_type (five result fields)
//   csr_      in         valid / ready      csr_index, csr_wdata
//
// Edge, clear, unused-kind and plain tick transactions answer the next cycle.
// A tick that recomputes the flow runs the serial interval x pulses-per-litre
// multiplier, then the serial divider, then a result state that loads the answer
// into the output register once it is free; no further request is taken before that.
// Reset clears all measurement state and loads the register defaults.
// A stalled result holds in the output register; req_stall is high while it
// is blocked or a calculation is in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_flow_rate_meter_unit import pfrm_pkg::*; #(
   parameter int FLOW_FRAC_BITS = FLOW_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int NUM_W = FLOW_SCALE_WIDTH + FLOW_FRAC_BITS + 8;
   localparam int DEN_W = TIME_WIDTH + PPL_WIDTH;
   localparam logic [NUM_W-1:0] FLOW_NUM = NUM_W'(FLOW_SCALE) << (FLOW_FRAC_BITS + 8);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_RESULT
   } state_type;

   // Configuration registers.
   logic [PPL_WIDTH-1:0]  ppl_ff;
   logic [TIME_WIDTH-1:0] min_gap_ff;
   logic [TIME_WIDTH-1:0] timeout_ff;

   // Measurement state.
   state_type             state_ff, state_in;
   logic [31:0]           count_ff, count_in;
   logic [31:0]           processed_ff, processed_in;
   logic [TIME_WIDTH-1:0] last_pulse_ff, last_pulse_in;
   logic [TIME_WIDTH-1:0] last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0] interval_ff, interval_in;
   logic                  seen_ff, seen_in;
   logic [FLOW_WIDTH-1:0] raw_ff, raw_in;
   logic [FLOW_WIDTH-1:0] filt_ff, filt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept_req;
   logic                  rsp_free;
   logic                  load_rsp;
   logic                  rej_in;
   logic [TIME_WIDTH-1:0] edge_gap;
   logic [TIME_WIDTH-1:0] pulse_age;
   logic                  timed_out;
   logic                  new_pulses;
   logic                  flow_blank;
   logic                  mul_start, mul_done;
   logic [DEN_W-1:0]      product;
   logic                  div_done;
   logic [FLOW_WIDTH-1:0] quotient;
   logic [FLOW_WIDTH+1:0] ema_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppl_ff     <= PPL_RESET;
         min_gap_ff <= MIN_GAP_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PPL:     ppl_ff     <= csr_wdata[PPL_WIDTH-1:0];
            CSR_MIN_GAP: min_gap_ff <= csr_wdata[TIME_WIDTH-1:0];
            CSR_TIMEOUT: timeout_ff <= csr_wdata[TIME_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign accept_req = req_valid && !req_stall;

   assign edge_gap   = req_data.now_us - last_edge_ff;
   assign pulse_age  = req_data.now_us - last_pulse_ff;
   assign timed_out  = (count_ff == '0) || (pulse_age > timeout_ff);
   assign new_pulses = count_ff != processed_ff;
   assign flow_blank = (interval_ff == '0) || (ppl_ff == '0);

   // Only a tick with fresh pulses, a usable period and no timeout needs the
   // arithmetic; every other case settles in the accepting cycle.
   assign mul_start = accept_req && (req_data.kind == KIND_TICK) && new_pulses
                      && !timed_out && !flow_blank;

   assign ema_sum = {2'b00, quotient} + {1'b0, filt_ff, 1'b0} + {2'b00, filt_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      processed_in  = processed_ff;
      last_pulse_in = last_pulse_ff;
      last_edge_in  = last_edge_ff;
      interval_in   = interval_ff;
      seen_in       = seen_ff;
      raw_in        = raw_ff;
      filt_in       = filt_ff;
      rej_in        = 1'b0;
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               load_rsp = 1'b1;
               unique case (req_data.kind)
                  KIND_EDGE: begin
                     rej_in       = seen_ff && (edge_gap < min_gap_ff);
                     last_edge_in = req_data.now_us;
                     seen_in      = 1'b1;
                     if (!rej_in) begin
                        interval_in   = (count_ff == '0) ? '0 : pulse_age;
                        last_pulse_in = req_data.now_us;
                        count_in      = count_ff + 32'd1;
                     end
                  end
                  KIND_TICK: begin
                     if (new_pulses) begin
                        processed_in = count_ff;
                     end
                     if (mul_start) begin
                        load_rsp = 1'b0;
                        state_in = ST_MUL;
                     end else if (timed_out || (new_pulses && flow_blank)) begin
                        raw_in  = '0;
                        filt_in = '0;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in      = '0;
                     processed_in  = '0;
                     last_pulse_in = '0;
                     last_edge_in  = '0;
                     interval_in   = '0;
                     seen_in       = 1'b0;
                     raw_in        = '0;
                     filt_in       = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               raw_in   = quotient;
               filt_in  = ema_sum[FLOW_WIDTH+1:2];
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_data_in.pulse_count       = count_in;
      rsp_data_in.pulse_interval_us = interval_in;
      rsp_data_in.raw_flow_q8       = raw_in;
      rsp_data_in.filtered_flow_q8  = filt_in;
      rsp_data_in.edge_rejected     = rej_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         processed_ff  <= '0;
         last_pulse_ff <= '0;
         last_edge_ff  <= '0;
         interval_ff   <= '0;
         seen_ff       <= 1'b0;
         raw_ff        <= '0;
         filt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         processed_ff  <= processed_in;
         last_pulse_ff <= last_pulse_in;
         last_edge_ff  <= last_edge_in;
         interval_ff   <= interval_in;
         seen_ff       <= seen_in;
         raw_ff        <= raw_in;
         filt_ff       <= filt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pfrm_mul #(
      .A_W (TIME_WIDTH),
      .B_W (PPL_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (interval_ff),
      .mplier  (ppl_ff),
      .done    (mul_done),
      .product (product)
   );

   pfrm_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (FLOW_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_done),
      .numer    (FLOW_NUM),
      .denom    (product),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule

// ===== src/pfrm_mul.sv =====
// ----------------------------------------------------------------------------
// Pulse flow rate meter: serial multiplier
// Shift-and-add product, one multiplier bit per cycle, least significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfrm_mul import pfrm_pkg::*; #(
   parameter int A_W = TIME_WIDTH,
   parameter int B_W = PPL_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   mcand,
   input  logic [B_W-1:0]   mplier,
   output logic             done,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [P_W-1:0]   mcand_ff, mcand_in;
   logic [B_W-1:0]   mplier_ff, mplier_in;
   logic [P_W-1:0]   acc_ff, acc_in;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(B_W);
         mcand_in  = P_W'(mcand);
         mplier_in = mplier;
         acc_in    = '0;
      end else if (active_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== src/pfrm_div.sv =====
// ----------------------------------------------------------------------------
// Pulse flow rate meter: serial divider
// Restoring division of a fixed numerator, one quotient bit per cycle, with
// the quotient saturated to Q_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfrm_div import pfrm_pkg::*; #(
   parameter int NUM_W = FLOW_SCALE_WIDTH + FLOW_FRAC_BITS_DEF + 8,
   parameter int DEN_W = TIME_WIDTH + PPL_WIDTH,
   parameter int Q_W   = FLOW_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [Q_W-1:0]   quotient
);

   // The divisor starts at denom * 2^Q_W and moves right one place a cycle.
   // One extra quotient bit above Q_W flags saturation; the lower bits are
   // then of no interest.
   localparam int CMP_W = DEN_W + Q_W;
   localparam int PAD_W = CMP_W - NUM_W;
   localparam int STEPS = Q_W + 1;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [CMP_W-1:0] div_ff, div_in;
   logic [Q_W:0]     quo_ff, quo_in;

   logic [CMP_W-1:0] rem_ext;
   logic [CMP_W-1:0] diff;
   logic             fits;

   assign rem_ext = {{PAD_W{1'b0}}, rem_ff};
   assign fits    = rem_ext >= div_ff;
   assign diff    = rem_ext - div_ff;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(STEPS);
         rem_in    = numer;
         div_in    = {denom, {Q_W{1'b0}}};
         quo_in    = '0;
      end else if (active_ff) begin
         if (fits) begin
            rem_in = diff[NUM_W-1:0];
         end
         div_in = div_ff >> 1;
         quo_in = {quo_ff[Q_W-1:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[Q_W] ? {Q_W{1'b1}} : quo_ff[Q_W-1:0];

endmodule

// ===== src/pfrm_checker.sv =====
// ----------------------------------------------------------------------------
// Pulse flow rate meter: port checker
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pulse_flow_rate_meter_unit_macros.svh"

module pfrm_checker import pfrm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A blocked result holds until it is taken.
   `PFRM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // No request transaction is taken while the output register is blocked.
   `PFRM_ASSERT_IMP(a_no_accept_blocked, clock, reset, rsp_valid && rsp_stall, req_stall)

   // Anything other than a tick answers in the following cycle.
   `PFRM_ASSERT_NXT(a_fast_answer, clock, reset, req_valid && !req_stall && (req_data.kind != KIND_TICK), rsp_valid)

   // A clear returns every result field to zero.
   `PFRM_ASSERT_NXT(a_clear_zero, clock, reset, req_valid && !req_stall && (req_data.kind == KIND_CLEAR), rsp_valid && (rsp_data == '0))

endmodule

bind pulse_flow_rate_meter_unit pfrm_checker u_pfrm_checker (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Pulse flow rate meter: self-checking testbench
// A scripted opening walks reset values, edge rejection, interval wrap,
// saturation, zero interval, zero pulses per litre, timeout and clear.
// Randomised phases with fresh register settings follow, and every result is
// compared with an in-bench model of the meter under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import pfrm_pkg::*;

   localparam logic [1:0]       KIND_UNUSED   = 2'd3;
   localparam longint unsigned  FLOW_NUMER    = 64'd60000000 << 16;
   localparam int               QUIET_LIMIT   = 5000;
   localparam int               SETTLE_CYCLES = 64;
   localparam int               PHASES        = 12;
   localparam int               PHASE_ITEMS   = 100;
   localparam int               REPORT_MAX    = 10;

   typedef struct {
      bit                         is_write;
      logic [CSR_INDEX_WIDTH-1:0] reg_index;
      logic [1:0]                 kind;
      logic [31:0]                value;
      bit                         typed;
      rsp_type                    want;
   } script_row_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Meter model: registers and measurement state.
   logic [PPL_WIDTH-1:0]  ppl_setting;
   logic [31:0]           min_gap_setting;
   logic [31:0]           timeout_setting;
   logic [31:0]           pulses_seen;
   logic [31:0]           last_pulse_us;
   logic [31:0]           period_us;
   logic [31:0]           last_edge_us;
   logic                  edge_seen;
   logic [31:0]           pulses_used;
   logic [FLOW_WIDTH-1:0] raw_flow;
   logic [FLOW_WIDTH-1:0] smooth_flow;

   rsp_type        expected_rsp[$];
   script_row_type script[$];
   int             send_idle_pct = 15;
   int             recv_idle_pct = 61;
   int             error_count   = 0;
   int             quiet_cycles  = 0;

   pulse_flow_rate_meter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [FLOW_WIDTH-1:0] flow_from_period(logic [31:0] period,
                                                              logic [PPL_WIDTH-1:0] ppl);
      longint unsigned q;
      if (period == 0 || ppl == 0)
         return '0;
      q = (FLOW_NUMER / longint'(period)) / longint'(ppl);
      return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic void clear_meter();
      pulses_seen   = '0;
      last_pulse_us = '0;
      period_us     = '0;
      last_edge_us  = '0;
      edge_seen     = 1'b0;
      pulses_used   = '0;
      raw_flow      = '0;
      smooth_flow   = '0;
   endfunction

   function automatic rsp_type meter_step(req_type item);
      rsp_type     r;
      logic [31:0] gap;
      logic [17:0] blend;
      r = '0;
      unique case (item.kind)
         KIND_EDGE: begin
            gap = item.now_us - last_edge_us;
            if (edge_seen && gap < min_gap_setting) begin
               r.edge_rejected = 1'b1;
            end else begin
               period_us     = (pulses_seen == 0) ? 32'd0 : item.now_us - last_pulse_us;
               last_pulse_us = item.now_us;
               pulses_seen   = pulses_seen + 32'd1;
            end
            last_edge_us = item.now_us;
            edge_seen    = 1'b1;
         end
         KIND_TICK: begin
            if (pulses_seen != pulses_used) begin
               pulses_used = pulses_seen;
               if (period_us == 0 || ppl_setting == 0) begin
                  raw_flow    = '0;
                  smooth_flow = '0;
               end else begin
                  raw_flow    = flow_from_period(period_us, ppl_setting);
                  blend       = 18'(raw_flow) + 18'(smooth_flow) * 18'd3;
                  smooth_flow = blend[17:2];
               end
            end
            if (pulses_seen == 0 || (item.now_us - last_pulse_us) > timeout_setting) begin
               raw_flow    = '0;
               smooth_flow = '0;
            end
         end
         KIND_CLEAR: clear_meter();
         default: ;
      endcase
      r.pulse_count       = pulses_seen;
      r.pulse_interval_us = period_us;
      r.raw_flow_q8       = raw_flow;
      r.filtered_flow_q8  = smooth_flow;
      return r;
   endfunction

   function automatic void plan_item(logic [1:0] kind, logic [31:0] now, bit typed = 1'b0,
                                     rsp_type want = '0);
      script_row_type row;
      row.is_write  = 1'b0;
      row.reg_index = '0;
      row.kind      = kind;
      row.value     = now;
      row.typed     = typed;
      row.want      = want;
      script.push_back(row);
   endfunction

   function automatic void plan_write(logic [CSR_INDEX_WIDTH-1:0] index, logic [31:0] value);
      script_row_type row;
      row.is_write  = 1'b1;
      row.reg_index = index;
      row.kind      = KIND_UNUSED;
      row.value     = value;
      row.typed     = 1'b0;
      row.want      = '0;
      script.push_back(row);
   endfunction

   // Each task below is entered just after a falling edge and returns just
   // after a falling edge, so that a valid is assigned at most once per step.
   task automatic push_item(input logic [1:0] kind, input logic [31:0] now,
                            input bit typed, input rsp_type want);
      req_type item;
      rsp_type model_rsp;
      item.kind   = kind;
      item.now_us = now;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      model_rsp = meter_step(item);
      expected_rsp.push_back(typed ? want : model_rsp);
      @(negedge clock);
   endtask

   // Registers change only once every transaction in flight has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      unique case (index)
         CSR_PPL:     ppl_setting     = value[PPL_WIDTH-1:0];
         CSR_MIN_GAP: min_gap_setting = value;
         CSR_TIMEOUT: timeout_setting = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic report_error(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("%0t: %s: expected count=%0d interval=%0d raw=%0d filt=%0d rej=%0b, got count=%0d interval=%0d raw=%0d filt=%0d rej=%0b",
                  $realtime, what, want.pulse_count, want.pulse_interval_us,
                  want.raw_flow_q8, want.filtered_flow_q8, want.edge_rejected,
                  got.pulse_count, got.pulse_interval_us, got.raw_flow_q8,
                  got.filtered_flow_q8, got.edge_rejected);
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_error("unexpected result", '0, rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.pulse_count       !== want.pulse_count ||
                rsp_data.pulse_interval_us !== want.pulse_interval_us ||
                rsp_data.raw_flow_q8       !== want.raw_flow_q8 ||
                rsp_data.filtered_flow_q8  !== want.filtered_flow_q8 ||
                rsp_data.edge_rejected     !== want.edge_rejected)
               report_error("result mismatch", want, rsp_data);
         end
      end
   end

   // Watchdog: a run that stops moving is a failure.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [31:0] clock_us;
      logic [31:0] step_us;
      logic [31:0] typical;
      logic [1:0]  kind;
      int          left;
      int          pick;

      ppl_setting     = PPL_RESET;
      min_gap_setting = MIN_GAP_RESET;
      timeout_setting = TIMEOUT_RESET;
      clear_meter();

      // Reset settings: no pulse yet, first pulse, period, timeout, wrap,
      // saturation, zero period, unused kind and clear.
      plan_item(KIND_TICK,  32'd0,       1'b1, rsp_type'{32'd0, 32'd0, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_EDGE,  32'd100,     1'b1, rsp_type'{32'd1, 32'd0, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_TICK,  32'd200,     1'b1, rsp_type'{32'd1, 32'd0, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_EDGE,  32'd10100,   1'b1, rsp_type'{32'd2, 32'd10000, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_TICK,  32'd10200);
      plan_item(KIND_TICK,  32'd10300);
      plan_item(KIND_TICK,  32'd1510101, 1'b1, rsp_type'{32'd2, 32'd10000, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_EDGE,  32'hFFFF_FFF0);
      plan_item(KIND_EDGE,  32'h0000_0010);
      plan_item(KIND_TICK,  32'h0000_0020);
      plan_item(KIND_EDGE,  32'h0000_0010);
      plan_item(KIND_TICK,  32'h0000_0010);
      plan_item(KIND_UNUSED, 32'hFFFF_FFFF);
      plan_item(KIND_CLEAR, 32'd0,       1'b1, rsp_type'{32'd0, 32'd0, 16'd0, 16'd0, 1'b0});
      // Minimum gap: the first edge always passes, close edges are rejected
      // and still move the reference point for the next edge.
      plan_write(CSR_MIN_GAP, 32'd1000);
      plan_item(KIND_EDGE,  32'd5000,    1'b1, rsp_type'{32'd1, 32'd0, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_EDGE,  32'd5999,    1'b1, rsp_type'{32'd1, 32'd0, 16'd0, 16'd0, 1'b1});
      plan_item(KIND_EDGE,  32'd6998,    1'b1, rsp_type'{32'd1, 32'd0, 16'd0, 16'd0, 1'b1});
      plan_item(KIND_EDGE,  32'd7998,    1'b1, rsp_type'{32'd2, 32'd2998, 16'd0, 16'd0, 1'b0});
      plan_write(CSR_PPL, 32'd0);
      plan_item(KIND_TICK,  32'd8000,    1'b1, rsp_type'{32'd2, 32'd2998, 16'd0, 16'd0, 1'b0});
      // Register extremes: largest pulses per litre and minimum gap with a zero timeout, then the reverse.
      plan_write(CSR_PPL,     32'h00FF_FFFF);
      plan_write(CSR_TIMEOUT, 32'd0);
      plan_write(CSR_MIN_GAP, 32'hFFFF_FFFF);
      plan_item(KIND_EDGE,  32'd100);
      plan_item(KIND_TICK,  32'd100);
      plan_item(KIND_CLEAR, 32'hFFFF_FFFF, 1'b1, rsp_type'{32'd0, 32'd0, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_EDGE,  32'd50,      1'b1, rsp_type'{32'd1, 32'd0, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_EDGE,  32'd49,      1'b1, rsp_type'{32'd2, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0});
      plan_item(KIND_TICK,  32'd49);
      plan_write(CSR_PPL,     32'd1);
      plan_write(CSR_TIMEOUT, 32'hFFFF_FFFF);
      plan_write(CSR_MIN_GAP, 32'd0);
      plan_item(KIND_EDGE,  32'd60);
      plan_item(KIND_TICK,  32'd60);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_write) begin
            settle();
            write_register(script[i].reg_index, script[i].value);
         end else begin
            push_item(script[i].kind, script[i].value, script[i].typed, script[i].want);
         end
      end

      clock_us = $urandom;
      for (int phase = 0; phase < PHASES; phase++) begin
         unique case (phase / (PHASES / 3))
            0:       begin send_idle_pct = 15; recv_idle_pct = 61; end
            1:       begin send_idle_pct = 61; recv_idle_pct = 15; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         settle();
         pick = $urandom_range(0, 9);
         write_register(CSR_PPL, (pick == 0) ? 32'd1 : (pick == 1) ? 32'h00FF_FFFF :
                                 (pick == 2) ? 32'd0 : $urandom_range(2000, 400000));
         pick = $urandom_range(0, 9);
         write_register(CSR_MIN_GAP, (pick < 2) ? 32'd0 : (pick == 2) ? 32'hFFFF_FFFF :
                                     (pick == 3) ? $urandom : $urandom_range(1, 5000));
         pick = $urandom_range(0, 9);
         write_register(CSR_TIMEOUT, (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                                     (pick == 2) ? $urandom : $urandom_range(5000, 2000000));

         // Mostly a plausible pulse train with ticks in between, spread
         // around the minimum gap; now and then a jump, a clear or noise.
         typical = (min_gap_setting != 0 && min_gap_setting < 100000) ? min_gap_setting
                                                                       : 32'd2000;
         left = PHASE_ITEMS;
         while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      kind = KIND_EDGE;
            else if (pick < 90) kind = KIND_TICK;
            else if (pick < 93) kind = KIND_CLEAR;
            else if (pick < 96) kind = KIND_UNUSED;
            else                kind = 2'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 60)      step_us = $urandom_range(0, 3 * typical + 200);
            else if (pick < 80) step_us = $urandom_range(0, 200);
            else if (pick < 92) step_us = $urandom_range(0, 3000000);
            else if (pick < 97) step_us = $urandom;
            else                step_us = 32'd0;
            clock_us = ($urandom_range(0, 99) < 4) ? $urandom : clock_us + step_us;
            push_item(kind, clock_us, 1'b0, '0);
            if (kind != KIND_UNUSED)
               left--;
         end
      end

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
